// ===== rtl/qnorm_pkg.sv =====
package qnorm_pkg;

  localparam int DIV_BITS = 32;
  localparam int RSQRT_STEPS_DEF = 3;
  localparam int WIN_W = 21;
  localparam logic [20:0] WINDOW_RESET = 21'd23170;

  typedef struct packed {
    logic        zero;
    logic        shortcut;
    logic [5:0]  shift;
    logic [39:0] d;
    logic [61:0] mn;
  } qnorm_cls_t;

  typedef struct packed {
    logic        zero;
    logic        shortcut;
    logic [5:0]  shift;
  } qnorm_info_t;

  typedef struct packed {
    logic [3:0][31:0] mag;
    logic [3:0]       neg;
    logic             flip;
  } qnorm_side_t;

  function automatic logic [31:0] rsqrt_seed(input logic [3:0] top);
    logic [31:0] s;
    case (top)
      4'd4:    s = 32'd2024667000;
      4'd5:    s = 32'd1831380200;
      4'd6:    s = 32'd1684624800;
      4'd7:    s = 32'd1568300300;
      4'd8:    s = 32'd1473161600;
      4'd9:    s = 32'd1393471400;
      4'd10:   s = 32'd1325455700;
      4'd11:   s = 32'd1266516800;
      4'd12:   s = 32'd1214800200;
      4'd13:   s = 32'd1168942000;
      4'd14:   s = 32'd1127913700;
      default: s = 32'd1090922800;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/qnorm_if.sv =====
interface qnorm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] q_scalar;
  logic [31:0] q_x;
  logic [31:0] q_y;
  logic [31:0] q_z;
  modport source (output valid, action, q_scalar, q_x, q_y, q_z, input ready);
  modport sink (input valid, action, q_scalar, q_x, q_y, q_z, output ready);
endinterface

interface qnorm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] r_scalar;
  logic [31:0] r_x;
  logic [31:0] r_y;
  logic [31:0] r_z;
  logic        zero_norm;
  modport source (output valid, r_scalar, r_x, r_y, r_z, zero_norm, input ready);
  modport sink (input valid, r_scalar, r_x, r_y, r_z, zero_norm, output ready);
endinterface

// ===== rtl/quaternion_normalizer_core.sv =====
// Channel  Direction  Contents
// in_q     sink       action, q_scalar, q_x, q_y, q_z (Q3.28)
// out_r    source     r_scalar, r_x, r_y, r_z (Q1.30), zero_norm
// cfg      write      cfg_we, cfg_wdata (shortcut window)
//
// One transaction is accepted per cycle while the pipeline is not held.
// The pipeline depth is set by the one-bit-per-stage divider for the shortcut factor.
// Reset clears the valid pipeline and loads the default window.
// The whole pipeline holds while a result waits at the output.
module quaternion_normalizer_core #(
  parameter int RSQRT_STEPS = qnorm_pkg::RSQRT_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  qnorm_in_if.sink    in_q,
  qnorm_out_if.source out_r,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata
);

  localparam int N = qnorm_pkg::DIV_BITS;
  localparam int SIDE_LAT = N + 2;
  localparam int LAT = N + 5;

  logic        en;
  logic [20:0] window_r;
  logic [LAT-1:0] vld_r;
  logic        act_r;
  logic [31:0] raw [0:3];
  logic [31:0] mag [0:3];
  logic [3:0]  neg;
  logic [63:0] sq [0:3];
  qnorm_pkg::qnorm_cls_t  cls;
  qnorm_pkg::qnorm_side_t side_w;
  qnorm_pkg::qnorm_side_t side_r [0:SIDE_LAT-1];
  qnorm_pkg::qnorm_info_t info_r [0:N-1];
  logic [31:0] div_q;
  logic [31:0] rs_y;
  logic [31:0] g;
  logic [31:0] res [0:3];
  logic        zero1_r, zero2_r;

  assign en = !vld_r[LAT-1] || out_r.ready;
  assign in_q.ready = en && rst_n;

  assign raw[0] = in_q.q_scalar;
  assign raw[1] = in_q.q_x;
  assign raw[2] = in_q.q_y;
  assign raw[3] = in_q.q_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= qnorm_pkg::WINDOW_RESET;
      vld_r    <= '0;
    end else begin
      if (cfg_we) window_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_q.valid};
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_sq
    qnorm_sq_lane u_sq (
      .clk   (clk),
      .en    (en),
      .raw   (raw[l]),
      .mag_r (mag[l]),
      .neg_r (neg[l]),
      .sq_r  (sq[l])
    );
    assign side_w.mag[l] = mag[l];
  end

  assign side_w.neg  = neg;
  assign side_w.flip = act_r && neg[0];

  qnorm_merge u_merge (
    .clk    (clk),
    .en     (en),
    .sq     (sq),
    .window (window_r),
    .cls_r  (cls)
  );

  qnorm_div u_div (
    .clk (clk),
    .en  (en),
    .d   (cls.d),
    .q   (div_q)
  );

  qnorm_rsqrt #(.STEPS(RSQRT_STEPS)) u_rsqrt (
    .clk (clk),
    .en  (en),
    .mn  (cls.mn),
    .y   (rs_y)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      act_r     <= in_q.action;
      side_r[0] <= side_w;
      for (int i = 1; i < SIDE_LAT; i++) side_r[i] <= side_r[i-1];
      info_r[0] <= '{zero: cls.zero, shortcut: cls.shortcut, shift: cls.shift};
      for (int i = 1; i < N; i++) info_r[i] <= info_r[i-1];
      zero1_r   <= info_r[N-1].zero;
      zero2_r   <= zero1_r;
    end
  end

  assign g = info_r[N-1].shortcut ? div_q : rs_y;

  for (genvar l = 0; l < 4; l++) begin : g_scale
    qnorm_scale_lane u_scale (
      .clk    (clk),
      .en     (en),
      .mag    (side_r[SIDE_LAT-1].mag[l]),
      .negate (side_r[SIDE_LAT-1].neg[l] ^ side_r[SIDE_LAT-1].flip),
      .zero   (info_r[N-1].zero),
      .g      (g),
      .shift  (info_r[N-1].shift),
      .r_r    (res[l])
    );
  end

  assign out_r.valid     = vld_r[LAT-1];
  assign out_r.r_scalar  = res[0];
  assign out_r.r_x       = res[1];
  assign out_r.r_y       = res[2];
  assign out_r.r_z       = res[3];
  assign out_r.zero_norm = zero2_r;

endmodule

// ===== rtl/qnorm_sq_lane.sv =====
module qnorm_sq_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] raw,
  output logic [31:0] mag_r,
  output logic        neg_r,
  output logic [63:0] sq_r
);

  logic [31:0] mag_nxt;

  assign mag_nxt = raw[31] ? (~raw + 32'd1) : raw;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= raw[31];
      sq_r  <= {32'd0, mag_nxt} * {32'd0, mag_nxt};
    end
  end

endmodule

// ===== rtl/qnorm_merge.sv =====
module qnorm_merge (
  input  logic                   clk,
  input  logic                   en,
  input  logic [63:0]            sq [0:3],
  input  logic [20:0]            window,
  output qnorm_pkg::qnorm_cls_t  cls_r
);

  logic [64:0]  m_r;
  logic [63:0]  m_lo;
  logic         carry;
  logic [63:0]  diff;
  logic [5:0]   p;
  logic [5:0]   pe;
  logic [127:0] wide;
  logic [39:0]  d_w;
  logic [64:0]  dsum;
  qnorm_pkg::qnorm_cls_t cls_nxt;

  localparam logic [63:0] ONE = 64'h0100_0000_0000_0000;

  assign m_lo  = m_r[63:0];
  assign carry = m_r[64];
  assign diff  = (m_lo >= ONE) ? (m_lo - ONE) : (ONE - m_lo);
  assign dsum  = {1'b0, ONE} + {1'b0, m_lo};
  assign d_w   = dsum[64:25];

  always_comb begin
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m_lo[i]) p = 6'(i);
    end
  end

  assign pe   = {p[5:1], 1'b0};
  assign wide = {62'd0, m_lo, 2'b00} << (6'd62 - pe);

  always_comb begin
    cls_nxt.zero     = !carry && (m_lo == 64'd0);
    cls_nxt.shortcut = !carry && (diff < {27'd0, window, 16'd0});
    cls_nxt.d        = d_w;
    if (carry) begin
      cls_nxt.mn    = 62'h1000_0000_0000_0000;
      cls_nxt.shift = 6'd33;
    end else begin
      cls_nxt.mn    = wide[65:4];
      cls_nxt.shift = 6'd1 + {1'b0, p[5:1]};
    end
    if (cls_nxt.shortcut) cls_nxt.shift = 6'd29;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r   <= {1'b0, sq[0]} + {1'b0, sq[1]} + {1'b0, sq[2]} + {1'b0, sq[3]};
      cls_r <= cls_nxt;
    end
  end

endmodule

// ===== rtl/qnorm_div.sv =====
module qnorm_div (
  input  logic        clk,
  input  logic        en,
  input  logic [39:0] d,
  output logic [31:0] q
);

  localparam int N = qnorm_pkg::DIV_BITS;

  logic [63:0] rem_r [0:N-1];
  logic [39:0] d_r   [0:N-1];
  logic [31:0] q_r   [0:N-1];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [63:0] rem_in;
    logic [39:0] d_in;
    logic [31:0] q_in;
    logic [71:0] dsh;
    logic        ge;

    if (s == 0) begin : g_first
      assign rem_in = 64'h8000_0000_0000_0000;
      assign d_in   = d;
      assign q_in   = 32'd0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign d_in   = d_r[s-1];
      assign q_in   = q_r[s-1];
    end

    assign dsh = {32'd0, d_in} << (N - 1 - s);
    assign ge  = {8'd0, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? (rem_in - dsh[63:0]) : rem_in;
        d_r[s]   <= d_in;
        q_r[s]   <= q_in | (32'(ge) << (N - 1 - s));
      end
    end
  end

  assign q = q_r[N-1];

endmodule

// ===== rtl/qnorm_rsqrt.sv =====
module qnorm_rsqrt #(
  parameter int STEPS = qnorm_pkg::RSQRT_STEPS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] mn,
  output logic [31:0] y
);

  localparam int PAD = qnorm_pkg::DIV_BITS - 1 - 3 * STEPS;
  localparam logic [34:0] THREE = 35'd3 << 31;

  logic [31:0] x0_r;
  logic [31:0] y0_r;
  logic [31:0] xs_r [0:STEPS-1];
  logic [31:0] ys_r [0:STEPS-1];
  logic [31:0] pad_r [0:PAD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= mn[61:30];
      y0_r <= qnorm_pkg::rsqrt_seed(mn[61:58]);
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [31:0] x_in, y_in;
    logic [31:0] xa_r, ya_r, xb_r, yb_r;
    logic [32:0] y2_r, t_r;
    logic [63:0] sq_w;
    logic [64:0] xz_w, yt_w;
    logic [34:0] z_w;
    logic [34:0] t_nxt;

    if (s == 0) begin : g_first
      assign x_in = x0_r;
      assign y_in = y0_r;
    end else begin : g_next
      assign x_in = xs_r[s-1];
      assign y_in = ys_r[s-1];
    end

    assign sq_w  = {32'd0, y_in} * {32'd0, y_in};
    assign xz_w  = {33'd0, xa_r} * {32'd0, y2_r};
    assign z_w   = xz_w[64:30];
    assign t_nxt = (z_w > THREE) ? 35'd0 : (THREE - z_w);
    assign yt_w  = {33'd0, yb_r} * {32'd0, t_r};

    always_ff @(posedge clk) begin
      if (en) begin
        xa_r     <= x_in;
        ya_r     <= y_in;
        y2_r     <= sq_w[63:31];
        xb_r     <= xa_r;
        yb_r     <= ya_r;
        t_r      <= t_nxt[32:0];
        xs_r[s]  <= xb_r;
        ys_r[s]  <= yt_w[63:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pad_r[0] <= ys_r[STEPS-1];
      for (int i = 1; i < PAD; i++) pad_r[i] <= pad_r[i-1];
    end
  end

  assign y = pad_r[PAD-1];

endmodule

// ===== rtl/qnorm_scale_lane.sv =====
module qnorm_scale_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag,
  input  logic        negate,
  input  logic        zero,
  input  logic [31:0] g,
  input  logic [5:0]  shift,
  output logic [31:0] r_r
);

  logic [63:0] prod_r;
  logic        negate_r;
  logic        zero_r;
  logic [5:0]  shift_r;
  logic [63:0] rnd;
  logic [63:0] sat;

  assign rnd = (prod_r + (64'd1 << (shift_r - 6'd1))) >> shift_r;
  assign sat = (rnd > (64'd1 << 30)) ? (64'd1 << 30) : rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= {32'd0, mag} * {32'd0, g};
      negate_r <= negate;
      zero_r   <= zero;
      shift_r  <= shift;
      if (zero_r) r_r <= 32'd0;
      else if (negate_r) r_r <= ~sat[31:0] + 32'd1;
      else r_r <= sat[31:0];
    end
  end

endmodule
